@@ hw/rtl/lcdws_pkg.sv @@
// Shared types and constants for the character LCD bus write sequencer.
package lcdws_pkg;

    localparam int unsigned TICK_W  = 10;
    localparam int unsigned LIMIT_W = 8;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CIDX_W  = 3;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_STROBE = 3'd1,
        PH_WAIT   = 3'd2,
        PH_PULSEA = 3'd3,
        PH_GAP    = 3'd4,
        PH_PULSEB = 3'd5
    } t_phase;

    typedef enum logic [CIDX_W-1:0] {
        REG_BUS_EIGHT_BIT = 3'd0,
        REG_PULSE_EIGHT   = 3'd1,
        REG_PULSE_FOUR    = 3'd2,
        REG_STROBE        = 3'd3,
        REG_POLL_INTERVAL = 3'd4,
        REG_POLL_LIMIT    = 3'd5
    } t_reg_idx;

    localparam logic [TICK_W-1:0]  RST_PULSE_EIGHT   = 10'd45;
    localparam logic [TICK_W-1:0]  RST_PULSE_FOUR    = 10'd100;
    localparam logic [TICK_W-1:0]  RST_STROBE        = 10'd450;
    localparam logic [TICK_W-1:0]  RST_POLL_INTERVAL = 10'd500;
    localparam logic [LIMIT_W-1:0] RST_POLL_LIMIT    = 8'd10;

    typedef struct packed {
        logic               bus_eight_bit;
        logic [TICK_W-1:0]  pulse_ticks_eight;
        logic [TICK_W-1:0]  pulse_ticks_four;
        logic [TICK_W-1:0]  strobe_ticks;
        logic [TICK_W-1:0]  poll_interval_ticks;
        logic [LIMIT_W-1:0] poll_limit;
    } t_cfg;

    typedef struct packed {
        logic              mode;
        logic [BYTE_W-1:0] data_byte;
        logic              is_data;
        logic              busy_line;
    } t_item;

    typedef struct packed {
        logic              pin_rs;
        logic              pin_rw;
        logic              pin_e;
        logic [BYTE_W-1:0] bus_pins;
        logic              db7_input;
        logic              ready_res;
        logic              done_res;
        logic              timed_out;
        logic              rejected;
    } t_result;

endpackage

@@ hw/rtl/char_lcd_bus_write_sequencer.sv @@
// Top level of the character LCD bus write sequencer.
//  channel   direction  handshake               payload
//  input     in         i_valid / o_ready       i_mode, i_data_byte, i_is_data, i_busy_line
//  result    out        o_valid / i_ready       o_pin_rs .. o_rejected
//  config    in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
// One item per clock sustained while the result side is not stalled; a transfer lands in the
// input register, and a step moves it through the phase/counter logic into the result
// register, from which the result is offered.
// A stalled result holds the result register; the input register still takes an
// item while it is empty, or while the result register is empty or drained that cycle.
// Synchronous reset restores the register defaults and the idle phase.
module char_lcd_bus_write_sequencer #(
    parameter int unsigned TICK_COUNTER_BITS = 10
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_mode,
    input  logic [lcdws_pkg::BYTE_W-1:0]  i_data_byte,
    input  logic                          i_is_data,
    input  logic                          i_busy_line,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_pin_rs,
    output logic                          o_pin_rw,
    output logic                          o_pin_e,
    output logic [lcdws_pkg::BYTE_W-1:0]  o_bus_pins,
    output logic                          o_db7_input,
    output logic                          o_ready_res,
    output logic                          o_done_res,
    output logic                          o_timed_out,
    output logic                          o_rejected,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [lcdws_pkg::CIDX_W-1:0]  i_cfg_index,
    input  logic [lcdws_pkg::TICK_W-1:0]  i_cfg_data
);
    import lcdws_pkg::*;

    t_cfg    cfg;
    t_item   r_in;
    logic    r_in_valid;
    t_result step_res;
    t_result r_out;
    logic    r_out_valid;
    logic    out_space;
    logic    step;

    assign out_space = !r_out_valid || i_ready;
    assign step      = r_in_valid && out_space;
    assign o_ready   = !r_in_valid || out_space;

    lcdws_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    lcdws_core #(
        .TICK_COUNTER_BITS (TICK_COUNTER_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_item   (r_in),
        .i_cfg    (cfg),
        .o_result (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in.mode      <= i_mode;
            r_in.data_byte <= i_data_byte;
            r_in.is_data   <= i_is_data;
            r_in.busy_line <= i_busy_line;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_space) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= step_res;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_pin_rs    = r_out.pin_rs;
    assign o_pin_rw    = r_out.pin_rw;
    assign o_pin_e     = r_out.pin_e;
    assign o_bus_pins  = r_out.bus_pins;
    assign o_db7_input = r_out.db7_input;
    assign o_ready_res = r_out.ready_res;
    assign o_done_res  = r_out.done_res;
    assign o_timed_out = r_out.timed_out;
    assign o_rejected  = r_out.rejected;

endmodule

@@ hw/rtl/lcdws_cfg.sv @@
// Configuration register file for the LCD write sequencer.
module lcdws_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [lcdws_pkg::CIDX_W-1:0]   i_cfg_index,
    input  logic [lcdws_pkg::TICK_W-1:0]   i_cfg_data,
    output lcdws_pkg::t_cfg                o_cfg
);
    import lcdws_pkg::*;

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bus_eight_bit       <= 1'b1;
            r_cfg.pulse_ticks_eight   <= RST_PULSE_EIGHT;
            r_cfg.pulse_ticks_four    <= RST_PULSE_FOUR;
            r_cfg.strobe_ticks        <= RST_STROBE;
            r_cfg.poll_interval_ticks <= RST_POLL_INTERVAL;
            r_cfg.poll_limit          <= RST_POLL_LIMIT;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_BUS_EIGHT_BIT: r_cfg.bus_eight_bit       <= i_cfg_data[0];
                REG_PULSE_EIGHT:   r_cfg.pulse_ticks_eight   <= i_cfg_data;
                REG_PULSE_FOUR:    r_cfg.pulse_ticks_four    <= i_cfg_data;
                REG_STROBE:        r_cfg.strobe_ticks        <= i_cfg_data;
                REG_POLL_INTERVAL: r_cfg.poll_interval_ticks <= i_cfg_data;
                REG_POLL_LIMIT:    r_cfg.poll_limit          <= i_cfg_data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

@@ hw/rtl/lcdws_core.sv @@
// Sequencer state and the per-item step: phase, tick and poll counters, pin latch.
module lcdws_core #(
    parameter int unsigned TICK_COUNTER_BITS = 10
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  lcdws_pkg::t_item    i_item,
    input  lcdws_pkg::t_cfg     i_cfg,
    output lcdws_pkg::t_result  o_result
);
    import lcdws_pkg::*;

    localparam int unsigned TB = TICK_COUNTER_BITS;
    localparam int unsigned CW = (TB > TICK_W) ? TB : TICK_W;

    t_phase              r_phase,  n_phase;
    logic [TB-1:0]       r_tick,   n_tick;
    logic [LIMIT_W-1:0]  r_poll,   n_poll;
    logic [BYTE_W-1:0]   r_held,   n_held;
    logic                r_sel,    n_sel;
    logic [BYTE_W-1:0]   r_pins,   n_pins;

    logic [TICK_W-1:0]   width;
    logic [CW-1:0]       width_ext;
    logic [CW-1:0]       target;
    logic [TB-1:0]       tick_inc;
    logic                elapsed;
    logic [LIMIT_W-1:0]  limit;
    logic [LIMIT_W-1:0]  poll_inc;
    logic [BYTE_W-1:0]   write_pins;
    logic                done, tmo, rej;

    always_comb begin
        // one width is live per phase, so a single tick comparator serves all
        case (r_phase)
            PH_STROBE: width = i_cfg.strobe_ticks;
            PH_WAIT:   width = i_cfg.poll_interval_ticks;
            PH_PULSEA: width = i_cfg.bus_eight_bit ? i_cfg.pulse_ticks_eight
                                                   : i_cfg.pulse_ticks_four;
            default:   width = i_cfg.pulse_ticks_four;
        endcase
        width_ext = CW'(width);
        if (width_ext == '0)
            target = CW'(1);
        else if (width_ext > CW'({TB{1'b1}}))
            target = CW'({TB{1'b1}});
        else
            target = width_ext;
        tick_inc = r_tick + TB'(1);
        elapsed  = CW'(tick_inc) >= target;
    end

    assign limit      = (i_cfg.poll_limit == '0) ? LIMIT_W'(1) : i_cfg.poll_limit;
    assign poll_inc   = r_poll + LIMIT_W'(1);
    assign write_pins = i_cfg.bus_eight_bit ? r_held : {r_held[7:4], r_pins[3:0]};

    always_comb begin
        n_phase = r_phase;
        n_tick  = r_tick;
        n_poll  = r_poll;
        n_held  = r_held;
        n_sel   = r_sel;
        n_pins  = r_pins;
        done    = 1'b0;
        tmo     = 1'b0;
        rej     = 1'b0;
        if (i_item.mode) begin
            if (r_phase == PH_IDLE) begin
                n_held  = i_item.data_byte;
                n_sel   = i_item.is_data;
                n_tick  = '0;
                n_poll  = '0;
                n_phase = PH_STROBE;
            end else begin
                rej = 1'b1;
            end
        end else begin
            if (r_phase != PH_IDLE && r_phase != PH_GAP)
                n_tick = elapsed ? '0 : tick_inc;
            unique case (r_phase)
                PH_STROBE: begin
                    if (elapsed) begin
                        if (i_item.busy_line) begin
                            n_phase = PH_WAIT;
                        end else begin
                            n_pins  = write_pins;
                            n_phase = PH_PULSEA;
                        end
                    end
                end
                PH_WAIT: begin
                    if (elapsed) begin
                        n_poll = poll_inc;
                        if (poll_inc >= limit) begin
                            n_phase = PH_IDLE;
                            done    = 1'b1;
                            tmo     = 1'b1;
                        end else if (!i_item.busy_line) begin
                            n_pins  = write_pins;
                            n_phase = PH_PULSEA;
                        end
                    end
                end
                PH_PULSEA: begin
                    if (elapsed) begin
                        if (i_cfg.bus_eight_bit) begin
                            n_phase = PH_IDLE;
                            done    = 1'b1;
                        end else begin
                            // low nibble moves onto pins 7..4 for the gap and second pulse
                            n_pins  = {r_held[3:0], r_pins[3:0]};
                            n_phase = PH_GAP;
                        end
                    end
                end
                PH_GAP: begin
                    n_tick  = '0;
                    n_phase = PH_PULSEB;
                end
                PH_PULSEB: begin
                    if (elapsed) begin
                        n_phase = PH_IDLE;
                        done    = 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        o_result           = '0;
        o_result.bus_pins  = n_pins;
        o_result.ready_res = (n_phase == PH_IDLE);
        o_result.done_res  = done;
        o_result.timed_out = tmo;
        o_result.rejected  = rej;
        unique case (n_phase) inside
            PH_STROBE: begin
                o_result.pin_rw    = 1'b1;
                o_result.pin_e     = 1'b1;
                o_result.db7_input = 1'b1;
            end
            PH_WAIT: begin
                o_result.pin_rw    = 1'b1;
                o_result.db7_input = 1'b1;
            end
            PH_PULSEA, PH_PULSEB: begin
                o_result.pin_rs = n_sel;
                o_result.pin_e  = 1'b1;
            end
            PH_GAP: begin
                o_result.pin_rs = n_sel;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_tick  <= '0;
            r_poll  <= '0;
            r_held  <= '0;
            r_sel   <= 1'b0;
            r_pins  <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_tick  <= n_tick;
            r_poll  <= n_poll;
            r_held  <= n_held;
            r_sel   <= n_sel;
            r_pins  <= n_pins;
        end
    end

endmodule

@@ hw/rtl/lcdws_chk.sv @@
// Port-level checker for the LCD write sequencer, bound to the top level.
module lcdws_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_valid,
    input logic                          i_ready,
    input logic                          o_pin_rs,
    input logic                          o_pin_rw,
    input logic                          o_pin_e,
    input logic [lcdws_pkg::BYTE_W-1:0]  o_bus_pins,
    input logic                          o_db7_input,
    input logic                          o_ready_res,
    input logic                          o_done_res,
    input logic                          o_timed_out,
    input logic                          o_rejected
);
    import lcdws_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_bus_pins) && $stable(o_pin_e)
            && $stable(o_done_res) && $stable(o_rejected))
        else $error("result changed while stalled");

    a_timeout_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_timed_out |-> o_done_res)
        else $error("timeout without done");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_done_res |-> o_ready_res && !o_rejected)
        else $error("done while not idle");

    a_idle_pins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_ready_res |-> !o_pin_e && !o_pin_rw && !o_pin_rs && !o_db7_input)
        else $error("control pins active while idle");

    a_db7_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_db7_input |-> o_pin_rw && !o_pin_rs)
        else $error("DB7 released outside a busy read");

endmodule

bind char_lcd_bus_write_sequencer lcdws_chk u_lcdws_chk (.*);

@@ test/tb_char_lcd_bus_write_sequencer.sv @@
// Self-checking testbench for the character LCD bus write sequencer.
module tb_char_lcd_bus_write_sequencer;
    timeunit 1ns;
    timeprecision 1ps;

    import lcdws_pkg::*;

    localparam int unsigned TCB          = 10;
    localparam int unsigned CNT_MAX      = (1 << TCB) - 1;
    localparam int unsigned LIMIT_CYCLES = 600000;
    localparam int unsigned DRAIN_CYCLES = 6;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned RANDOM_ITEMS = 120;

    localparam logic MODE_TICK  = 1'b0;
    localparam logic MODE_WRITE = 1'b1;

    // indexes past the register list; writes there must be ignored
    localparam logic [CIDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CIDX_W-1:0] REG_SPARE_B = 3'd7;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_valid     = 1'b0;
    logic                 o_ready;
    logic                 i_mode      = MODE_TICK;
    logic [BYTE_W-1:0]    i_data_byte = '0;
    logic                 i_is_data   = 1'b0;
    logic                 i_busy_line = 1'b0;
    logic                 o_valid;
    logic                 i_ready     = 1'b0;
    logic                 o_pin_rs;
    logic                 o_pin_rw;
    logic                 o_pin_e;
    logic [BYTE_W-1:0]    o_bus_pins;
    logic                 o_db7_input;
    logic                 o_ready_res;
    logic                 o_done_res;
    logic                 o_timed_out;
    logic                 o_rejected;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CIDX_W-1:0]    i_cfg_index = '0;
    logic [TICK_W-1:0]    i_cfg_data  = '0;

    char_lcd_bus_write_sequencer #(
        .TICK_COUNTER_BITS(TCB)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_mode      (i_mode),
        .i_data_byte (i_data_byte),
        .i_is_data   (i_is_data),
        .i_busy_line (i_busy_line),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_pin_rs    (o_pin_rs),
        .o_pin_rw    (o_pin_rw),
        .o_pin_e     (o_pin_e),
        .o_bus_pins  (o_bus_pins),
        .o_db7_input (o_db7_input),
        .o_ready_res (o_ready_res),
        .o_done_res  (o_done_res),
        .o_timed_out (o_timed_out),
        .o_rejected  (o_rejected),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // predicted sequencer state and register copy
    t_cfg              exp_cfg;
    t_phase            exp_phase;
    logic [TCB-1:0]    exp_ticks;
    logic [LIMIT_W-1:0] exp_polls;
    logic [BYTE_W-1:0] exp_byte;
    logic              exp_select;
    logic [BYTE_W-1:0] exp_pins;

    t_result     pending_pin_states[$];
    int unsigned errors        = 0;
    int unsigned active_items  = 0;
    int unsigned writes_seen   = 0;
    int unsigned timeouts_seen = 0;
    int unsigned rejects_seen  = 0;
    int unsigned cycles        = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned hold_token    = 0;
    int unsigned hold_seen     = 0;
    int unsigned hold_left     = 0;

    // ---------------------------------------------------------------- predictor

    function automatic bit advance_ticks(logic [TICK_W-1:0] width);
        int unsigned target;
        target = (width == 0) ? 1 : width;
        if (target > CNT_MAX) target = CNT_MAX;
        exp_ticks = exp_ticks + 1'b1;
        if (exp_ticks >= target) begin
            exp_ticks = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void begin_write();
        if (exp_cfg.bus_eight_bit) begin
            exp_pins = exp_byte;
        end else begin
            exp_pins = {exp_byte[7:4], exp_pins[3:0]};
        end
        exp_ticks = '0;
        exp_phase = PH_PULSEA;
    endfunction

    function automatic t_result predict_pin_state(t_item it);
        t_result            r;
        logic [LIMIT_W-1:0] limit;
        r = '0;
        limit = (exp_cfg.poll_limit == 0) ? 8'd1 : exp_cfg.poll_limit;
        if (it.mode == MODE_WRITE) begin
            if (exp_phase == PH_IDLE) begin
                exp_byte   = it.data_byte;
                exp_select = it.is_data;
                exp_ticks  = '0;
                exp_polls  = '0;
                exp_phase  = PH_STROBE;
            end else begin
                r.rejected = 1'b1;
            end
        end else begin
            case (exp_phase)
                PH_STROBE: begin
                    if (advance_ticks(exp_cfg.strobe_ticks)) begin
                        if (it.busy_line) exp_phase = PH_WAIT;
                        else begin_write();
                    end
                end
                PH_WAIT: begin
                    if (advance_ticks(exp_cfg.poll_interval_ticks)) begin
                        exp_polls = exp_polls + 1'b1;
                        if (exp_polls >= limit) begin
                            exp_phase   = PH_IDLE;
                            r.done_res  = 1'b1;
                            r.timed_out = 1'b1;
                        end else if (!it.busy_line) begin
                            begin_write();
                        end
                    end
                end
                PH_PULSEA: begin
                    if (advance_ticks(exp_cfg.bus_eight_bit ? exp_cfg.pulse_ticks_eight
                                                            : exp_cfg.pulse_ticks_four)) begin
                        if (exp_cfg.bus_eight_bit) begin
                            exp_phase  = PH_IDLE;
                            r.done_res = 1'b1;
                        end else begin
                            // low nibble goes out on pins 7..4 already during the gap
                            exp_pins  = {exp_byte[3:0], exp_pins[3:0]};
                            exp_phase = PH_GAP;
                        end
                    end
                end
                PH_GAP: begin
                    exp_ticks = '0;
                    exp_phase = PH_PULSEB;
                end
                PH_PULSEB: begin
                    if (advance_ticks(exp_cfg.pulse_ticks_four)) begin
                        exp_phase  = PH_IDLE;
                        r.done_res = 1'b1;
                    end
                end
                default: ;
            endcase
        end
        case (exp_phase) inside
            PH_STROBE: begin
                r.pin_rw = 1'b1; r.pin_e = 1'b1; r.db7_input = 1'b1;
            end
            PH_WAIT: begin
                r.pin_rw = 1'b1; r.db7_input = 1'b1;
            end
            PH_PULSEA, PH_PULSEB: begin
                r.pin_rs = exp_select; r.pin_e = 1'b1;
            end
            PH_GAP: begin
                r.pin_rs = exp_select;
            end
            default: ;
        endcase
        r.bus_pins  = exp_pins;
        r.ready_res = (exp_phase == PH_IDLE);
        return r;
    endfunction

    // ---------------------------------------------------------------- drivers

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_item(t_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_mode      <= it.mode;
        i_data_byte <= it.data_byte;
        i_is_data   <= it.is_data;
        i_busy_line <= it.busy_line;
        do @(posedge i_clk); while (!o_ready);
        if ((exp_phase != PH_IDLE) ? (it.mode == MODE_TICK) : (it.mode == MODE_WRITE))
            active_items++;
        pending_pin_states.push_back(predict_pin_state(it));
        @(negedge i_clk);
    endtask

    task automatic tick(logic busy);
        t_item it;
        it.mode      = MODE_TICK;
        it.data_byte = BYTE_W'($urandom_range(255));
        it.is_data   = 1'($urandom_range(1));
        it.busy_line = busy;
        send_item(it);
    endtask

    task automatic request(logic [BYTE_W-1:0] data, logic sel);
        t_item it;
        it.mode      = MODE_WRITE;
        it.data_byte = data;
        it.is_data   = sel;
        it.busy_line = 1'($urandom_range(1));
        send_item(it);
    endtask

    // request, then ticks until the write ends; noisy runs add stray requests
    // and now and then stop early so the next request lands on a busy block
    task automatic run_write(logic [BYTE_W-1:0] data, logic sel, int unsigned busy_pct,
                             bit noisy);
        int unsigned n;
        int unsigned cut;
        n = 0;
        cut = (noisy && $urandom_range(9) == 0) ? $urandom_range(1, 3) : 32'hFFFF_FFFF;
        request(data, sel);
        while (exp_phase != PH_IDLE && n < cut) begin
            if (noisy && $urandom_range(99) < 4)
                request(BYTE_W'($urandom_range(255)), 1'($urandom_range(1)));
            else
                tick($urandom_range(99) < busy_pct);
            n++;
        end
    endtask

    // finish any write, then wait for every result plus the pipeline depth
    task automatic settle();
        while (exp_phase != PH_IDLE) tick(1'($urandom_range(1)));
        i_valid <= 1'b0;
        while (pending_pin_states.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CIDX_W-1:0] idx, logic [TICK_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_BUS_EIGHT_BIT: exp_cfg.bus_eight_bit       = data[0];
            REG_PULSE_EIGHT:   exp_cfg.pulse_ticks_eight   = data;
            REG_PULSE_FOUR:    exp_cfg.pulse_ticks_four    = data;
            REG_STROBE:        exp_cfg.strobe_ticks        = data;
            REG_POLL_INTERVAL: exp_cfg.poll_interval_ticks = data;
            REG_POLL_LIMIT:    exp_cfg.poll_limit          = data[LIMIT_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic load_config(logic [TICK_W-1:0] bus, logic [TICK_W-1:0] p8,
                               logic [TICK_W-1:0] p4, logic [TICK_W-1:0] strobe,
                               logic [TICK_W-1:0] interval, logic [TICK_W-1:0] limit);
        write_reg(REG_BUS_EIGHT_BIT, bus);
        write_reg(REG_PULSE_EIGHT, p8);
        write_reg(REG_PULSE_FOUR, p4);
        write_reg(REG_STROBE, strobe);
        write_reg(REG_POLL_INTERVAL, interval);
        write_reg(REG_POLL_LIMIT, limit);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [TICK_W-1:0] rand_width();
        return ($urandom_range(7) == 0) ? TICK_W'($urandom_range(40))
                                        : TICK_W'($urandom_range(6));
    endfunction

    // receiver: random stalls, plus a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_token != hold_seen) begin
            hold_seen <= hold_token;
            hold_left <= HOLD_CYCLES;
            i_ready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_ready   <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ---------------------------------------------------------------- checker

    task automatic check_field(string name, logic [BYTE_W-1:0] exp_v, logic [BYTE_W-1:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_valid === 1'b1 && i_ready) begin
            if (pending_pin_states.size() == 0) begin
                $error("result transfer with no pending expectation");
                errors++;
            end else begin
                want = pending_pin_states.pop_front();
                check_field("pin_rs", BYTE_W'(want.pin_rs), BYTE_W'(o_pin_rs));
                check_field("pin_rw", BYTE_W'(want.pin_rw), BYTE_W'(o_pin_rw));
                check_field("pin_e", BYTE_W'(want.pin_e), BYTE_W'(o_pin_e));
                check_field("bus_pins", want.bus_pins, o_bus_pins);
                check_field("db7_input", BYTE_W'(want.db7_input), BYTE_W'(o_db7_input));
                check_field("ready_res", BYTE_W'(want.ready_res), BYTE_W'(o_ready_res));
                check_field("done_res", BYTE_W'(want.done_res), BYTE_W'(o_done_res));
                check_field("timed_out", BYTE_W'(want.timed_out), BYTE_W'(o_timed_out));
                check_field("rejected", BYTE_W'(want.rejected), BYTE_W'(o_rejected));
                if (want.done_res && !want.timed_out) writes_seen++;
                if (want.timed_out) timeouts_seen++;
                if (want.rejected) rejects_seen++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results pending", cycles,
                     pending_pin_states.size());
            $display("status: fail");
            $finish;
        end
    end

    // ---------------------------------------------------------------- tests

    // one 8-bit write with the register values left by reset
    task automatic test_reset_defaults();
        run_write(8'h3C, 1'b1, 0, 1'b0);
        settle();
    endtask

    task automatic test_directed();
        load_config(10'd1, 10'd1, 10'd1, 10'd1, 10'd1, 10'd1);
        tick(1'b1);                      // idle pins stay low
        request(8'hFF, 1'b1);
        request(8'h00, 1'b0);            // rejected during the strobe
        tick(1'b0);
        tick(1'b1);
        settle();
        // zero widths and zero poll limit act as one; 4-bit bus shows the nibble gap
        load_config(10'h3FE, 10'd0, 10'd0, 10'd0, 10'd0, 10'h300);
        write_reg(REG_SPARE_A, 10'd1);
        write_reg(REG_SPARE_B, 10'h3FF);
        i_cfg_valid <= 1'b0;
        request(8'hA5, 1'b0);
        repeat (4) tick(1'b0);
        request(8'h00, 1'b1);            // busy at every sample: times out
        tick(1'b1);
        tick(1'b1);
        settle();
        write_reg(REG_POLL_LIMIT, 10'd2);
        i_cfg_valid <= 1'b0;
        request(8'h5A, 1'b1);            // one busy wait, then the write
        tick(1'b1);
        repeat (4) tick(1'b0);
        settle();
    endtask

    // largest poll limit reached with zero strobe and interval widths
    task automatic test_extremes();
        load_config(10'h3FF, 10'd1, 10'd1023, 10'd0, 10'd0, 10'h0FF);
        run_write(8'h81, 1'b0, 0, 1'b0);
        run_write(8'h7E, 1'b1, 100, 1'b0);
        settle();
    endtask

    task automatic test_random(int unsigned send_pct, int unsigned recv_pct,
                               int unsigned n_items);
        int unsigned goal;
        int unsigned busy_pct;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int r = 0; r < 4; r++) begin
            settle();
            load_config(TICK_W'($urandom_range(1023)), rand_width(), rand_width(),
                        rand_width(), rand_width(),
                        {2'($urandom_range(3)), 8'($urandom_range(4))});
            goal = active_items + n_items / 4;
            while (active_items < goal) begin
                if ($urandom_range(9) == 0)
                    repeat ($urandom_range(1, 3)) tick(1'($urandom_range(1)));
                case ($urandom_range(3))
                    0: busy_pct = 0;
                    1: busy_pct = 25;
                    2: busy_pct = 60;
                    default: busy_pct = 100;
                endcase
                run_write(BYTE_W'($urandom_range(255)), 1'($urandom_range(1)), busy_pct, 1'b1);
            end
        end
        settle();
    endtask

    // receiver holds off while items keep coming, so the input side stalls
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        load_config(10'd1, 10'd2, 10'd2, 10'd3, 10'd2, 10'd3);
        hold_token++;
        repeat (8) run_write(BYTE_W'($urandom_range(255)), 1'($urandom_range(1)), 30, 1'b0);
        settle();
    endtask

    initial begin
        exp_cfg.bus_eight_bit       = 1'b1;
        exp_cfg.pulse_ticks_eight   = RST_PULSE_EIGHT;
        exp_cfg.pulse_ticks_four    = RST_PULSE_FOUR;
        exp_cfg.strobe_ticks        = RST_STROBE;
        exp_cfg.poll_interval_ticks = RST_POLL_INTERVAL;
        exp_cfg.poll_limit          = RST_POLL_LIMIT;
        exp_phase  = PH_IDLE;
        exp_ticks  = '0;
        exp_polls  = '0;
        exp_byte   = '0;
        exp_select = 1'b0;
        exp_pins   = '0;
        send_idle_pct = 24;
        recv_idle_pct = 70;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_defaults();
        test_directed();
        test_extremes();
        test_random(24, 70, RANDOM_ITEMS / 3);
        test_random(70, 24, RANDOM_ITEMS / 3);
        test_backpressure();
        test_random(0, 0, RANDOM_ITEMS / 3);

        $display("covered reset defaults, 8/4-bit writes, zero widths, the largest poll limit");
        $display("%0d writes, %0d busy timeouts, %0d rejected requests, %0d cycles",
                 writes_seen, timeouts_seen, rejects_seen, cycles);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/lcdws_pkg.sv
hw/rtl/lcdws_cfg.sv
hw/rtl/lcdws_core.sv
hw/rtl/char_lcd_bus_write_sequencer.sv
hw/rtl/lcdws_chk.sv
test/tb_char_lcd_bus_write_sequencer.sv
